### rtl/sia_pkg.sv
// shared types, constants and step functions of the saturating interval unit
package sia_pkg;

  localparam int WORD_BITS  = 64;
  localparam int FIELD_BITS = 64;
  localparam int NUM_LANES  = 4;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_AND = 3'd5;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [WORD_BITS-1:0] uword_t;
  typedef logic signed [FIELD_BITS-1:0] field_t;

  localparam word_t  MAX_W  = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t  MIN_W  = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam uword_t HALF_U = {1'b1, {(WORD_BITS-1){1'b0}}};

  // one lane of the bit-serial engine: multiplicand or divisor, shifting
  // operand/quotient, accumulator or partial remainder, sticky overflow
  typedef struct packed {
    uword_t x;
    uword_t y;
    uword_t acc;
    logic   ovf;
  } lane_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [NUM_LANES-1:0] neg;
    logic                 full;
    logic                 swap;
    logic                 single;
    logic                 empty;
    word_t                amin;
    word_t                amax;
    word_t                da;
    word_t                pmin;
    word_t                pmax;
  } side_t;

  function automatic uword_t mag(word_t v);
    return v[WORD_BITS-1] ? uword_t'(-v) : uword_t'(v);
  endfunction

  function automatic word_t neg_u(uword_t u);
    return word_t'(~u + uword_t'(1));
  endfunction

  function automatic word_t smin(word_t a, word_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic word_t smax(word_t a, word_t b);
    return (a > b) ? a : b;
  endfunction

  // one bit of shift-and-add multiply or restoring divide, msb first
  function automatic lane_t lane_step(lane_t l, logic mul);
    logic [WORD_BITS:0] t;
    uword_t             r;
    lane_t              o;
    o = l;
    if (mul) begin
      t = {l.acc, 1'b0} + (l.y[WORD_BITS-1] ? {1'b0, l.x} : '0);
      o.ovf = l.ovf | (t > {1'b0, HALF_U});
      o.acc = t[WORD_BITS-1:0];
      o.y   = {l.y[WORD_BITS-2:0], 1'b0};
    end else begin
      r = {l.acc[WORD_BITS-2:0], l.y[WORD_BITS-1]};
      if (r >= l.x) begin
        o.acc = r - l.x;
        o.y   = {l.y[WORD_BITS-2:0], 1'b1};
      end else begin
        o.acc = r;
        o.y   = {l.y[WORD_BITS-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

### rtl/sia_in_if.sv
// request channel: operation code and two operand intervals
interface sia_in_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                operation;
  logic signed [sia_pkg::FIELD_BITS-1:0] left_min;
  logic signed [sia_pkg::FIELD_BITS-1:0] left_max;
  logic signed [sia_pkg::FIELD_BITS-1:0] right_min;
  logic signed [sia_pkg::FIELD_BITS-1:0] right_max;

  modport source (output valid, operation, left_min, left_max, right_min, right_max,
                  input ready);
  modport sink   (input valid, operation, left_min, left_max, right_min, right_max,
                  output ready);
endinterface

### rtl/sia_out_if.sv
// result channel: bounding interval and empty flag
interface sia_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [sia_pkg::FIELD_BITS-1:0] result_min;
  logic signed [sia_pkg::FIELD_BITS-1:0] result_max;
  logic                      result_empty;

  modport source (output valid, result_min, result_max, result_empty, input ready);
  modport sink   (input valid, result_min, result_max, result_empty, output ready);
endinterface

### rtl/saturating_interval_arith_top.sv
// top level of the saturating interval arithmetic unit
//
// in_i carries one request word: an operation code (add, subtract,
// multiply, divide, modulo, bit-and) and two signed intervals. out_o
// returns one word per request: the bounding interval, saturated at the
// signed word limits, plus an empty flag for modulo.
// the datapath is a decode register, a chain of WORD_BITS identical cells
// and an output register. each cell does one bit of shift-and-add multiply
// (four endpoint products) or restoring divide (two dividends sharing one
// divisor) and hands its lanes to the next cell.
// throughput: one word per cycle while out_o.ready is high; every stage
// has its own valid bit.
// when out_o.ready is low the output register holds its word; stages behind
// it keep moving into empty slots, so in_i.ready stays high until the chain
// is full. reset clears all valid bits; no word is in flight after reset.
// add, subtract, bit-and and unused codes are settled in decode and ride
// the chain unchanged.
module saturating_interval_arith_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  sia_in_if.sink     in_i,
  sia_out_if.source  out_o
);

  localparam int W = sia_pkg::WORD_BITS;

  // stage 0 is the decode register, stages 1..W are the cells
  logic [W:0]                              valid;
  logic [W+1:0]                            en;
  sia_pkg::lane_t [sia_pkg::NUM_LANES-1:0] lanes [W+1];
  sia_pkg::side_t                          side  [W+1];

  sia_pkg::lane_t [sia_pkg::NUM_LANES-1:0] pre_lanes;
  sia_pkg::side_t                          pre_side;
  logic                                    valid0_q;
  sia_pkg::lane_t [sia_pkg::NUM_LANES-1:0] lanes0_q;
  sia_pkg::side_t                          side0_q;

  sia_pkg::field_t res_min, res_max;
  logic            res_empty;
  logic            out_valid_q;
  sia_pkg::field_t out_min_q, out_max_q;
  logic            out_empty_q;

  // a stage may load when it is empty or its successor loads
  assign en[W+1] = !out_valid_q || out_o.ready;
  for (genvar g = 0; g <= W; g++) begin : g_en
    assign en[g] = !valid[g] || en[g+1];
  end
  assign in_i.ready = en[0];

  sia_pre u_pre (
    .operation_i (in_i.operation),
    .left_min_i  (in_i.left_min),
    .left_max_i  (in_i.left_max),
    .right_min_i (in_i.right_min),
    .right_max_i (in_i.right_max),
    .lanes_o     (pre_lanes),
    .side_o      (pre_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (en[0]) begin
      valid0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      lanes0_q <= pre_lanes;
      side0_q  <= pre_side;
    end
  end

  assign valid[0] = valid0_q;
  assign lanes[0] = lanes0_q;
  assign side[0]  = side0_q;

  // one cell per word bit, msb first
  for (genvar g = 1; g <= W; g++) begin : g_cell
    sia_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[g]),
      .valid_i (valid[g-1]),
      .lanes_i (lanes[g-1]),
      .side_i  (side[g-1]),
      .valid_o (valid[g]),
      .lanes_o (lanes[g]),
      .side_o  (side[g])
    );
  end

  sia_post u_post (
    .lanes_i        (lanes[W]),
    .side_i         (side[W]),
    .result_min_o   (res_min),
    .result_max_o   (res_max),
    .result_empty_o (res_empty)
  );

  // output register parts the chain from the receiver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[W+1]) begin
      out_valid_q <= valid[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[W+1]) begin
      out_min_q   <= res_min;
      out_max_q   <= res_max;
      out_empty_q <= res_empty;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_min   = out_min_q;
  assign out_o.result_max   = out_max_q;
  assign out_o.result_empty = out_empty_q;

endmodule

### rtl/sia_pre.sv
// operand decode: direct results and lane setup for the cell chain
module sia_pre (
  input  logic [2:0]                                 operation_i,
  input  sia_pkg::field_t                            left_min_i,
  input  sia_pkg::field_t                            left_max_i,
  input  sia_pkg::field_t                            right_min_i,
  input  sia_pkg::field_t                            right_max_i,
  output sia_pkg::lane_t [sia_pkg::NUM_LANES-1:0]    lanes_o,
  output sia_pkg::side_t                             side_o
);

  localparam int W = sia_pkg::WORD_BITS;

  sia_pkg::word_t amin, amax, bmin, bmax, ds, abs_bmin, abs_bmax, da;
  sia_pkg::uword_t dv;
  logic signed [W:0] add_min, add_max, sub_min, sub_max;

  function automatic sia_pkg::word_t sat_wide(logic signed [W:0] s);
    if (s[W] != s[W-1]) return s[W] ? sia_pkg::MIN_W : sia_pkg::MAX_W;
    return s[W-1:0];
  endfunction

  function automatic sia_pkg::word_t s_abs(sia_pkg::word_t v);
    if (v == sia_pkg::MIN_W) return sia_pkg::MAX_W;
    return (v < 0) ? -v : v;
  endfunction

  assign amin = sia_pkg::word_t'(left_min_i);
  assign amax = sia_pkg::word_t'(left_max_i);
  assign bmin = sia_pkg::word_t'(right_min_i);
  assign bmax = sia_pkg::word_t'(right_max_i);

  assign add_min = (W+1)'(amin) + (W+1)'(bmin);
  assign add_max = (W+1)'(amax) + (W+1)'(bmax);
  assign sub_min = (W+1)'(amin) - (W+1)'(bmax);
  assign sub_max = (W+1)'(amax) - (W+1)'(bmin);

  assign ds       = (bmax < 0) ? bmax : bmin;
  assign abs_bmin = s_abs(bmin);
  assign abs_bmax = s_abs(bmax);
  assign da       = sia_pkg::smax(abs_bmin, abs_bmax);
  assign dv       = (operation_i == sia_pkg::OP_DIV) ? sia_pkg::mag(ds) : sia_pkg::uword_t'(da);

  always_comb begin
    side_o        = '0;
    side_o.op     = operation_i;
    side_o.full   = (bmin <= 0) && (bmax >= 0);
    side_o.swap   = ds[W-1];
    side_o.single = (bmin == bmax) && (bmin != sia_pkg::MAX_W) && (bmin != sia_pkg::MIN_W);
    side_o.empty  = side_o.single && ((amax < amin) || (da == 0));
    side_o.amin   = amin;
    side_o.amax   = amax;
    side_o.da     = da;
    side_o.pmin   = sia_pkg::MIN_W;
    side_o.pmax   = sia_pkg::MAX_W;
    case (operation_i)
      sia_pkg::OP_ADD: begin
        side_o.pmin = sat_wide(add_min);
        side_o.pmax = sat_wide(add_max);
      end
      sia_pkg::OP_SUB: begin
        side_o.pmin = sat_wide(sub_min);
        side_o.pmax = sat_wide(sub_max);
      end
      sia_pkg::OP_AND: begin
        if (amin < 0) begin
          if (bmin >= 0) begin
            side_o.pmin = '0;
            side_o.pmax = bmax;
          end
        end else begin
          side_o.pmin = '0;
          side_o.pmax = (bmin < 0) ? amax : sia_pkg::smin(amax, bmax);
        end
      end
      default: begin
      end
    endcase

    lanes_o = '0;
    if (operation_i == sia_pkg::OP_MUL) begin
      lanes_o[0].x = sia_pkg::mag(amin);
      lanes_o[0].y = sia_pkg::mag(bmin);
      lanes_o[1].x = sia_pkg::mag(amin);
      lanes_o[1].y = sia_pkg::mag(bmax);
      lanes_o[2].x = sia_pkg::mag(amax);
      lanes_o[2].y = sia_pkg::mag(bmin);
      lanes_o[3].x = sia_pkg::mag(amax);
      lanes_o[3].y = sia_pkg::mag(bmax);
      side_o.neg   = {amax[W-1] ^ bmax[W-1], amax[W-1] ^ bmin[W-1],
                      amin[W-1] ^ bmax[W-1], amin[W-1] ^ bmin[W-1]};
    end else begin
      lanes_o[0].x = dv;
      lanes_o[0].y = sia_pkg::mag(amin);
      lanes_o[1].x = dv;
      lanes_o[1].y = sia_pkg::mag(amax);
      side_o.neg   = {2'b00, amax[W-1] ^ ds[W-1], amin[W-1] ^ ds[W-1]};
    end
  end

endmodule

### rtl/sia_cell.sv
// one cell of the chain: one multiply or divide bit on every lane, registered
module sia_cell (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  sia_pkg::lane_t [sia_pkg::NUM_LANES-1:0]    lanes_i,
  input  sia_pkg::side_t                             side_i,
  output logic                                       valid_o,
  output sia_pkg::lane_t [sia_pkg::NUM_LANES-1:0]    lanes_o,
  output sia_pkg::side_t                             side_o
);

  logic                                    valid_q;
  sia_pkg::lane_t [sia_pkg::NUM_LANES-1:0] lanes_d, lanes_q;
  sia_pkg::side_t                          side_q;

  always_comb begin
    for (int k = 0; k < sia_pkg::NUM_LANES; k++) begin
      lanes_d[k] = sia_pkg::lane_step(lanes_i[k], side_i.op == sia_pkg::OP_MUL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;
  assign side_o  = side_q;

endmodule

### rtl/sia_post.sv
// result assembly: signs, saturation, min/max and modulo bounds
module sia_post (
  input  sia_pkg::lane_t [sia_pkg::NUM_LANES-1:0] lanes_i,
  input  sia_pkg::side_t                          side_i,
  output sia_pkg::field_t                         result_min_o,
  output sia_pkg::field_t                         result_max_o,
  output logic                                    result_empty_o
);

  localparam int W = sia_pkg::WORD_BITS;

  sia_pkg::word_t [sia_pkg::NUM_LANES-1:0] prod;
  sia_pkg::word_t  q0, q1, m0, m1, dm1, rmin, rmax;
  sia_pkg::uword_t lim [sia_pkg::NUM_LANES];
  logic signed [W:0] span_m, span_a;
  logic empty;

  function automatic sia_pkg::word_t quot(sia_pkg::uword_t q, logic neg);
    if (neg) return sia_pkg::neg_u(q);
    return (q == sia_pkg::HALF_U) ? sia_pkg::MAX_W : sia_pkg::word_t'(q);
  endfunction

  always_comb begin
    for (int k = 0; k < sia_pkg::NUM_LANES; k++) begin
      lim[k] = side_i.neg[k] ? sia_pkg::HALF_U : sia_pkg::HALF_U - sia_pkg::uword_t'(1);
      if (lanes_i[k].ovf || (lanes_i[k].acc > lim[k])) begin
        prod[k] = side_i.neg[k] ? sia_pkg::MIN_W : sia_pkg::MAX_W;
      end else begin
        prod[k] = side_i.neg[k] ? sia_pkg::neg_u(lanes_i[k].acc)
                                : sia_pkg::word_t'(lanes_i[k].acc);
      end
    end
  end

  assign q0 = quot(lanes_i[0].y, side_i.neg[0]);
  assign q1 = quot(lanes_i[1].y, side_i.neg[1]);

  // remainder carries the sign of the dividend
  assign m0 = side_i.amin[W-1] ? sia_pkg::neg_u(lanes_i[0].acc)
                               : sia_pkg::word_t'(lanes_i[0].acc);
  assign m1 = side_i.amax[W-1] ? sia_pkg::neg_u(lanes_i[1].acc)
                               : sia_pkg::word_t'(lanes_i[1].acc);
  assign span_m = (W+1)'(m1) - (W+1)'(m0);
  assign span_a = (W+1)'(side_i.amax) - (W+1)'(side_i.amin);
  assign dm1    = side_i.da - sia_pkg::word_t'(1);

  always_comb begin
    rmin  = side_i.pmin;
    rmax  = side_i.pmax;
    empty = 1'b0;
    case (side_i.op)
      sia_pkg::OP_MUL: begin
        rmin = sia_pkg::smin(sia_pkg::smin(prod[0], prod[1]), sia_pkg::smin(prod[2], prod[3]));
        rmax = sia_pkg::smax(sia_pkg::smax(prod[0], prod[1]), sia_pkg::smax(prod[2], prod[3]));
      end
      sia_pkg::OP_DIV: begin
        if (!side_i.full) begin
          rmin = side_i.swap ? q1 : q0;
          rmax = side_i.swap ? q0 : q1;
        end
      end
      sia_pkg::OP_MOD: begin
        if (side_i.empty) begin
          rmin  = '0;
          rmax  = '0;
          empty = 1'b1;
        end else if (side_i.single && (m1 >= m0) && (span_m == span_a)) begin
          rmin = m0;
          rmax = m1;
        end else begin
          rmin = sia_pkg::smax(sia_pkg::smin(side_i.amin, '0), -dm1);
          rmax = sia_pkg::smin(sia_pkg::smax(side_i.amax, '0), dm1);
        end
      end
      default: begin
      end
    endcase
  end

  assign result_min_o   = sia_pkg::FIELD_BITS'(rmin);
  assign result_max_o   = sia_pkg::FIELD_BITS'(rmax);
  assign result_empty_o = empty;

endmodule
